/* sv/fdt_structure_tokenizer_unit_macros.svh */
// assertion helpers shared by the tokenizer rtl
`ifndef FDT_STRUCTURE_TOKENIZER_UNIT_MACROS_SVH
`define FDT_STRUCTURE_TOKENIZER_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define FDTST_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fdtst assertion failed");

// next-cycle implication, checked out of reset
`define FDTST_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fdtst assertion failed");

`endif

/* sv/fdtst_pkg.sv */
`timescale 1ns / 1ps

package fdtst_pkg;

   localparam int unsigned AddrWidthDefault = 32;
   localparam int unsigned CsrAddrWidth     = 4;

   // structure block tokens
   localparam logic [31:0] TOK_BEGIN_NODE = 32'd1;
   localparam logic [31:0] TOK_END_NODE   = 32'd2;
   localparam logic [31:0] TOK_PROP       = 32'd3;
   localparam logic [31:0] TOK_NOP        = 32'd4;
   localparam logic [31:0] TOK_END        = 32'd9;

   // register indexes (paddr[3:2])
   localparam logic [1:0] REG_STRUCT_BASE  = 2'd0;
   localparam logic [1:0] REG_STRINGS_BASE = 2'd1;
   localparam logic [1:0] REG_BLOCK_LENGTH = 2'd2;

   typedef enum logic [2:0] {
      EV_BEGIN_NODE = 3'd0,
      EV_END_NODE   = 3'd1,
      EV_PROP       = 3'd2,
      EV_NOP        = 3'd3,
      EV_END        = 3'd4,
      EV_BAD_TOKEN  = 3'd5,
      EV_PAST_LIMIT = 3'd6
   } event_type;

   typedef enum logic [2:0] {
      MODE_TOKEN = 3'd0,
      MODE_NAME  = 3'd1,
      MODE_PLEN  = 3'd2,
      MODE_PNAME = 3'd3,
      MODE_PDATA = 3'd4,
      MODE_STOP  = 3'd5
   } mode_type;

   typedef struct packed {
      logic [31:0] word;
      logic        restart;
   } req_type;

   typedef struct packed {
      event_type   event_res;
      logic [31:0] token_address;
      logic [31:0] name_address;
      logic [31:0] data_address;
      logic [31:0] data_length;
   } rsp_type;

endpackage

/* sv/fdt_structure_tokenizer_unit.sv */
`timescale 1ns / 1ps

// Device-tree structure block tokenizer. Feed the structure block one big-endian
// 32-bit word per beat on req_ (restart=1 on the first word of a block); each
// token comes back as one rsp_ beat: begin node with its name address, end node,
// nop, end, property (on its name-offset word, with length, name address in the
// strings block and data address), bad token or past limit. Name and data words
// give no beat. End, bad token and past limit stop the parse; later words are
// swallowed until a restart. The unit takes one word per clock unless req_stall
// is high: a word lands in the input register, the mode update and address adds
// run in the next cycle and the beat is loaded into the result register once that
// register is free. req_stall rises only when the word in the input register yields a
// beat while the result register is still held by rsp_stall. Program
// struct_base, strings_base and block_length over the csr_ port while idle.
module fdt_structure_tokenizer_unit #(
   parameter int unsigned ADDR_WIDTH = fdtst_pkg::AddrWidthDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // word stream
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  fdtst_pkg::req_type                   req_data,
   // token events
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output fdtst_pkg::rsp_type                   rsp_data,
   // register port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [fdtst_pkg::CsrAddrWidth-1:0]   csr_paddr,
   input  logic [31:0]                          csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);

`include "fdt_structure_tokenizer_unit_macros.svh"

   // addresses wrap at ADDR_WIDTH and are then reported in 32 bits
   localparam logic [31:0] AddrMask = (ADDR_WIDTH >= 32) ? 32'hFFFF_FFFF :
                                      32'((64'd1 << ADDR_WIDTH) - 64'd1);

   function automatic logic [31:0] addr_wrap(input logic [31:0] base,
                                             input logic [31:0] off);
      logic [31:0] sum;
      sum = base + off;
      return sum & AddrMask;
   endfunction

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   logic [31:0] struct_base_ff,  struct_base_in;
   logic [31:0] strings_base_ff, strings_base_in;
   logic [31:0] block_length_ff, block_length_in;
   logic        csr_write;
   logic [1:0]  csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = csr_paddr[3:2];

   always_comb begin
      struct_base_in  = struct_base_ff;
      strings_base_in = strings_base_ff;
      block_length_in = block_length_ff;
      csr_prdata      = 32'd0;
      unique case (csr_index)
         fdtst_pkg::REG_STRUCT_BASE: begin
            csr_prdata = struct_base_ff;
            if (csr_write) struct_base_in = csr_pwdata;
         end
         fdtst_pkg::REG_STRINGS_BASE: begin
            csr_prdata = strings_base_ff;
            if (csr_write) strings_base_in = csr_pwdata;
         end
         fdtst_pkg::REG_BLOCK_LENGTH: begin
            csr_prdata = block_length_ff;
            if (csr_write) block_length_in = csr_pwdata;
         end
         default: begin
            // unmapped index: reads zero, writes dropped
            csr_prdata = 32'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         struct_base_ff  <= 32'd0;
         strings_base_ff <= 32'd0;
         block_length_ff <= 32'hFFFF_FFFF;
      end else begin
         struct_base_ff  <= struct_base_in;
         strings_base_ff <= strings_base_in;
         block_length_ff <= block_length_in;
      end
   end

   // ---------------------------------------------------------------------
   // input register
   // ---------------------------------------------------------------------
   logic               s1_valid_ff, s1_valid_in;
   fdtst_pkg::req_type s1_data_ff;
   logic               s1_go;      // word in the input register is consumed
   logic               produce;    // that word yields a beat
   logic               out_free;   // result register can take a beat
   logic               req_take;

   assign out_free  = ~rsp_valid | ~rsp_stall;
   assign s1_go     = s1_valid_ff & (~produce | out_free);
   assign req_stall = s1_valid_ff & ~s1_go;
   assign req_take  = req_valid & ~req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take)   s1_valid_in = 1'b1;
      else if (s1_go) s1_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= s1_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_take) s1_data_ff <= req_data;
   end

   // ---------------------------------------------------------------------
   // parse state
   // ---------------------------------------------------------------------
   fdtst_pkg::mode_type mode_ff, mode_in, cur_mode;
   logic [31:0]         pos_ff, pos_in, cur_pos;
   logic [29:0]         skip_ff, skip_in, cur_skip;
   logic [31:0]         hlen_ff, hlen_in;   // property length
   logic [31:0]         htok_ff, htok_in;   // property token offset
   fdtst_pkg::rsp_type  beat;
   logic [31:0]         word;
   logic [31:0]         here_addr;
   logic [31:0]         next_addr;
   logic [32:0]         len_round;
   logic                has_nul;

   assign word = s1_data_ff.word;

   // restart clears position, mode and skip count before the word is parsed
   assign cur_mode = s1_data_ff.restart ? fdtst_pkg::MODE_TOKEN : mode_ff;
   assign cur_pos  = s1_data_ff.restart ? 32'd0 : pos_ff;
   assign cur_skip = s1_data_ff.restart ? 30'd0 : skip_ff;

   assign here_addr = addr_wrap(struct_base_ff, cur_pos);
   assign next_addr = addr_wrap(struct_base_ff, cur_pos + 32'd4);
   assign len_round = {1'b0, hlen_ff} + 33'd3;
   assign has_nul   = (word[31:24] == 8'd0) | (word[23:16] == 8'd0) |
                      (word[15:8] == 8'd0)  | (word[7:0] == 8'd0);

   always_comb begin
      mode_in = cur_mode;
      skip_in = cur_skip;
      hlen_in = hlen_ff;
      htok_in = htok_ff;
      produce = 1'b0;
      beat.event_res     = fdtst_pkg::EV_NOP;
      beat.token_address = here_addr;
      beat.name_address  = 32'd0;
      beat.data_address  = 32'd0;
      beat.data_length   = 32'd0;

      unique case (cur_mode)
         fdtst_pkg::MODE_TOKEN: begin
            produce = 1'b1;
            if (cur_pos >= block_length_ff) begin
               beat.event_res = fdtst_pkg::EV_PAST_LIMIT;
               mode_in        = fdtst_pkg::MODE_STOP;
            end else begin
               case (word)
                  fdtst_pkg::TOK_BEGIN_NODE: begin
                     beat.event_res    = fdtst_pkg::EV_BEGIN_NODE;
                     beat.name_address = next_addr;
                     mode_in           = fdtst_pkg::MODE_NAME;
                  end
                  fdtst_pkg::TOK_END_NODE: begin
                     beat.event_res = fdtst_pkg::EV_END_NODE;
                  end
                  fdtst_pkg::TOK_PROP: begin
                     // event waits for the name-offset word
                     produce = 1'b0;
                     htok_in = cur_pos;
                     mode_in = fdtst_pkg::MODE_PLEN;
                  end
                  fdtst_pkg::TOK_NOP: begin
                     beat.event_res = fdtst_pkg::EV_NOP;
                  end
                  fdtst_pkg::TOK_END: begin
                     beat.event_res = fdtst_pkg::EV_END;
                     mode_in        = fdtst_pkg::MODE_STOP;
                  end
                  default: begin
                     beat.event_res = fdtst_pkg::EV_BAD_TOKEN;
                     mode_in        = fdtst_pkg::MODE_STOP;
                  end
               endcase
            end
         end
         fdtst_pkg::MODE_NAME: begin
            if (has_nul) mode_in = fdtst_pkg::MODE_TOKEN;
         end
         fdtst_pkg::MODE_PLEN: begin
            hlen_in = word;
            mode_in = fdtst_pkg::MODE_PNAME;
         end
         fdtst_pkg::MODE_PNAME: begin
            produce            = 1'b1;
            beat.event_res     = fdtst_pkg::EV_PROP;
            beat.token_address = addr_wrap(struct_base_ff, htok_ff);
            beat.name_address  = addr_wrap(strings_base_ff, word);
            beat.data_address  = next_addr;
            beat.data_length   = hlen_ff;
            if (hlen_ff == 32'd0) begin
               mode_in = fdtst_pkg::MODE_TOKEN;
            end else begin
               // padded data words left after the first one
               skip_in = 30'(len_round[32:2] - 31'd1);
               mode_in = fdtst_pkg::MODE_PDATA;
            end
         end
         fdtst_pkg::MODE_PDATA: begin
            if (cur_skip == 30'd0) mode_in = fdtst_pkg::MODE_TOKEN;
            else                   skip_in = cur_skip - 30'd1;
         end
         fdtst_pkg::MODE_STOP: begin
            mode_in = fdtst_pkg::MODE_STOP;
         end
         default: begin
            mode_in = fdtst_pkg::MODE_STOP;
         end
      endcase

      // a stopped parse holds its position unless the word gave a beat
      if (mode_in != fdtst_pkg::MODE_STOP || produce) pos_in = cur_pos + 32'd4;
      else                                            pos_in = cur_pos;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= fdtst_pkg::MODE_TOKEN;
         pos_ff  <= 32'd0;
         skip_ff <= 30'd0;
         hlen_ff <= 32'd0;
         htok_ff <= 32'd0;
      end else if (s1_go) begin
         mode_ff <= mode_in;
         pos_ff  <= pos_in;
         skip_ff <= skip_in;
         hlen_ff <= hlen_in;
         htok_ff <= htok_in;
      end
   end

   // ---------------------------------------------------------------------
   // result register
   // ---------------------------------------------------------------------
   logic               rsp_valid_ff, rsp_valid_in;
   fdtst_pkg::rsp_type rsp_data_ff;
   logic               rsp_load;

   assign rsp_load = s1_go & produce;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load)        rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (rsp_load) rsp_data_ff <= beat;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------
   `FDTST_ASSERT_NOW(a_skip_only_in_data, clock, reset,
      skip_ff != 30'd0, mode_ff == fdtst_pkg::MODE_PDATA)

   `FDTST_ASSERT_NOW(a_data_fields_prop_only, clock, reset,
      rsp_valid && rsp_data.event_res != fdtst_pkg::EV_PROP,
      rsp_data.data_address == 32'd0 && rsp_data.data_length == 32'd0)

   `FDTST_ASSERT_NEXT(a_stop_after_final_event, clock, reset,
      rsp_load && (beat.event_res == fdtst_pkg::EV_END ||
                   beat.event_res == fdtst_pkg::EV_BAD_TOKEN ||
                   beat.event_res == fdtst_pkg::EV_PAST_LIMIT),
      mode_ff == fdtst_pkg::MODE_STOP)

   `FDTST_ASSERT_NOW(a_no_beat_from_skipped_words, clock, reset,
      s1_valid_ff && !s1_data_ff.restart && (mode_ff == fdtst_pkg::MODE_NAME ||
         mode_ff == fdtst_pkg::MODE_PLEN || mode_ff == fdtst_pkg::MODE_PDATA ||
         mode_ff == fdtst_pkg::MODE_STOP),
      !produce)

endmodule
